/* rtl/dsvm_pkg.sv */
// ----------------------------------------------------------------------------
// dsvm_pkg
// Shared types and constants for the drum sample voice mixer: request
// operation codes, note-to-slot map, gain table constants, MAC control.
// ----------------------------------------------------------------------------
`default_nettype none

package dsvm_pkg;

   // Request operation codes (carried on req_tuser)
   localparam logic [1:0] OP_NOTE_ON = 2'd0;
   localparam logic [1:0] OP_LOAD    = 2'd1;
   localparam logic [1:0] OP_FRAME   = 2'd2;

   // Sample slots: kick, snare, closed hat, open hat, crash, ride, tom
   localparam int SampleSlots = 7;
   localparam int SLOT_W      = 3;
   localparam int SLOT_CODES  = 8;
   localparam logic [SLOT_W-1:0] SLOT_NONE = 3'd7;

   // Field widths
   localparam int GAIN_W   = 15;
   localparam int WORD_W   = 16;
   localparam int LEN_W    = 15;
   localparam int INDEX_W  = 14;
   localparam int MIX_W    = 19;
   localparam int COUNT_W  = 4;
   localparam int PROD_W   = 31;

   // gain = floor((velocity * GainMul + GainRnd) / GainDiv), Q0.15
   localparam int GainMul  = 229376;
   localparam int GainRnd  = 635;
   localparam int GainDiv  = 1270;
   localparam int VEL_CODES = 128;

   // Output saturation limits, Q4.15
   localparam int MixMax = 262143;
   localparam int MixMin = -262144;

   // Control from the sequencer to the MAC unit
   typedef struct packed {
      logic clear;   // start of frame: zero accumulator and pipe
      logic valid;   // word/gain pair on the inputs is from an active voice
   } mac_ctl_type;

   // MIDI drum note to sample slot
   function automatic logic [SLOT_W-1:0] slot_for_note(input logic [6:0] note);
      logic [SLOT_W-1:0] slot;
      unique case (note)
         7'd35, 7'd36:                              slot = 3'd0;
         7'd38, 7'd40:                              slot = 3'd1;
         7'd42:                                     slot = 3'd2;
         7'd46:                                     slot = 3'd3;
         7'd49, 7'd57:                              slot = 3'd4;
         7'd51:                                     slot = 3'd5;
         7'd41, 7'd43, 7'd45, 7'd47, 7'd48, 7'd50:  slot = 3'd6;
         default:                                   slot = SLOT_NONE;
      endcase
      return slot;
   endfunction

endpackage

`default_nettype wire

/* rtl/dsvm_mac.sv */
// ----------------------------------------------------------------------------
// dsvm_mac
// Shared multiply-accumulate unit: one gain x word product per cycle,
// exact accumulation, round half up to Q4.15 and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module dsvm_mac #(
   parameter int VOICES = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire dsvm_pkg::mac_ctl_type                ctl,
   input  wire logic [dsvm_pkg::GAIN_W-1:0]          gain,
   input  wire logic signed [dsvm_pkg::WORD_W-1:0]   word,
   output logic signed [dsvm_pkg::MIX_W-1:0]         mix
);

   localparam int ACC_W = dsvm_pkg::PROD_W + 1 + $clog2(VOICES);
   localparam int RND_W = ACC_W - 15;
   localparam int EXT_W = (RND_W > dsvm_pkg::MIX_W + 1) ? RND_W : dsvm_pkg::MIX_W + 1;

   logic signed [dsvm_pkg::PROD_W-1:0] prod_ff;
   logic signed [dsvm_pkg::PROD_W-1:0] prod_in;
   logic                               prod_valid_ff;
   logic signed [ACC_W-1:0]            acc_ff;
   logic signed [ACC_W-1:0]            acc_in;
   logic signed [ACC_W-1:0]            acc_rnd;
   logic signed [RND_W-1:0]            rnd;
   logic signed [EXT_W-1:0]            rnd_ext;
   logic signed [2*dsvm_pkg::WORD_W-1:0] prod_full;

   // multiply stage
   assign prod_full = $signed({1'b0, gain}) * word;
   assign prod_in   = prod_full[dsvm_pkg::PROD_W-1:0];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctl.valid;
      end
   end

   // accumulate stage
   always_comb begin
      acc_in = acc_ff;
      if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // round half up: floor((acc + 2^14) / 2^15), then saturate
   assign acc_rnd = acc_ff + ACC_W'(16384);
   assign rnd     = acc_rnd[ACC_W-1:15];
   assign rnd_ext = EXT_W'(rnd);

   always_comb begin
      if (rnd_ext > EXT_W'(dsvm_pkg::MixMax)) begin
         mix = dsvm_pkg::MIX_W'(dsvm_pkg::MixMax);
      end else if (rnd_ext < EXT_W'(dsvm_pkg::MixMin)) begin
         mix = dsvm_pkg::MIX_W'(dsvm_pkg::MixMin);
      end else begin
         mix = rnd_ext[dsvm_pkg::MIX_W-1:0];
      end
   end

endmodule

`default_nettype wire

/* rtl/drum_sample_voice_mixer_top.sv */
// ----------------------------------------------------------------------------
// drum_sample_voice_mixer_top
// Seven drum sample stores and a pool of playback voices. Requests load
// sample words, start voices on MIDI notes, or render one mixed frame.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                 | tuser     | tlast
//  req     | in  | note,velocity,id,index,value (48 bits) | operation | load_last
//  rsp     | out | mix_value, active_voices (24 bits)    | -         | -
//
//  A load request leaves the block in idle. A note-on scans the voices for
//  the lowest free one. A frame walks the voices one per cycle through the
//  shared MAC and the registered sample memory read, then passes through the
//  DRAIN1 and DRAIN2 states. A load or note-on is taken while a result
//  waits; a frame's result stalls in the done state until rsp is free.
//  Synchronous reset clears voices and sample lengths; sample words are
//  undefined until written and get no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module drum_sample_voice_mixer_top #(
   parameter int VOICES       = 8,
   parameter int SAMPLE_DEPTH = 16384
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: note[6:0], velocity[13:7], sample_id[16:14],
   //            sample_index[30:17], sample_value[46:31], zero[47]
   input  wire logic [47:0] req_tdata,
   input  wire logic [1:0]  req_tuser,   // operation[1:0]
   input  wire logic        req_tlast,   // load_last
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata: mix_value[18:0], active_voices[22:19], zero[23]
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready
);

   localparam int VW      = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int IDX_W   = $clog2(SAMPLE_DEPTH);
   localparam int IW      = (IDX_W > dsvm_pkg::INDEX_W) ? IDX_W : dsvm_pkg::INDEX_W;
   localparam int PW      = (IDX_W > dsvm_pkg::LEN_W) ? IDX_W : dsvm_pkg::LEN_W;
   localparam int CW0     = $clog2(VOICES + 1);
   localparam int CNT_W   = (CW0 > dsvm_pkg::COUNT_W) ? CW0 : dsvm_pkg::COUNT_W;
   localparam int ADDR_W  = dsvm_pkg::SLOT_W + IDX_W;
   localparam int MEM_DEPTH = dsvm_pkg::SampleSlots << IDX_W;
   localparam int CMP_W   = 22;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_ISSUE  = 3'd2;
   localparam logic [2:0] ST_DRAIN1 = 3'd3;
   localparam logic [2:0] ST_DRAIN2 = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   // request fields
   logic [6:0]                        req_note;
   logic [6:0]                        req_velocity;
   logic [dsvm_pkg::SLOT_W-1:0]       req_sample_id;
   logic [dsvm_pkg::INDEX_W-1:0]      req_sample_index;
   logic signed [dsvm_pkg::WORD_W-1:0] req_sample_value;
   logic                              req_accept;

   assign req_note         = req_tdata[6:0];
   assign req_velocity     = req_tdata[13:7];
   assign req_sample_id    = req_tdata[16:14];
   assign req_sample_index = req_tdata[30:17];
   assign req_sample_value = req_tdata[46:31];
   assign req_accept       = req_tvalid && req_tready;

   // gain table, Q0.15
   logic [dsvm_pkg::GAIN_W-1:0] gain_rom [dsvm_pkg::VEL_CODES];
   for (genvar g = 0; g < dsvm_pkg::VEL_CODES; g++) begin : g_gain
      assign gain_rom[g] = dsvm_pkg::GAIN_W'((g * dsvm_pkg::GainMul + dsvm_pkg::GainRnd)
                                              / dsvm_pkg::GainDiv);
   end

   // state
   logic [2:0]                   state_ff, state_in;
   logic [VW-1:0]                cnt_ff, cnt_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [dsvm_pkg::SLOT_W-1:0]  note_slot_ff, note_slot_in;
   logic [dsvm_pkg::LEN_W-1:0]   note_len_ff, note_len_in;
   logic [dsvm_pkg::GAIN_W-1:0]  note_gain_ff, note_gain_in;
   logic                         s1_valid_ff, s1_valid_in;
   logic [dsvm_pkg::GAIN_W-1:0]  s1_gain_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [23:0]                  rsp_data_ff;
   logic                         rsp_load;

   logic [dsvm_pkg::LEN_W-1:0]   sample_len_ff [dsvm_pkg::SLOT_CODES];
   logic                         voice_active_ff [VOICES];
   logic [dsvm_pkg::SLOT_W-1:0]  voice_sample_ff [VOICES];
   logic [dsvm_pkg::LEN_W-1:0]   voice_pos_ff    [VOICES];
   logic [dsvm_pkg::LEN_W-1:0]   voice_len_ff    [VOICES];
   logic [dsvm_pkg::GAIN_W-1:0]  voice_gain_ff   [VOICES];

   logic signed [dsvm_pkg::WORD_W-1:0] sample_mem [MEM_DEPTH];
   logic signed [dsvm_pkg::WORD_W-1:0] rd_word_ff;

   logic                         load_ok;
   logic                         mem_we;
   logic [IW-1:0]                idx_ext;
   logic [ADDR_W-1:0]            mem_waddr;
   logic [ADDR_W-1:0]            mem_raddr;
   logic [PW-1:0]                pos_ext;
   logic [dsvm_pkg::LEN_W-1:0]   pos_next;
   logic                         voice_start;
   logic                         voice_step;
   logic                         voice_ends;
   logic                         cnt_last;
   dsvm_pkg::mac_ctl_type        mac_ctl;
   logic signed [dsvm_pkg::MIX_W-1:0] mix;

   assign req_tready = (state_ff == ST_IDLE);
   assign cnt_last   = (cnt_ff == VW'(VOICES - 1));

   // load decode
   assign load_ok   = (req_sample_id != dsvm_pkg::SLOT_NONE)
                      && (CMP_W'(req_sample_index) < CMP_W'(SAMPLE_DEPTH));
   assign mem_we    = req_accept && (req_tuser == dsvm_pkg::OP_LOAD) && load_ok;
   assign idx_ext   = IW'(req_sample_index);
   assign mem_waddr = {req_sample_id, idx_ext[IDX_W-1:0]};

   // current voice read address and position step
   assign pos_ext    = PW'(voice_pos_ff[cnt_ff]);
   assign mem_raddr  = {voice_sample_ff[cnt_ff], pos_ext[IDX_W-1:0]};
   assign pos_next   = voice_pos_ff[cnt_ff] + dsvm_pkg::LEN_W'(1);
   assign voice_ends = (pos_next >= voice_len_ff[cnt_ff]);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      count_in     = count_ff;
      note_slot_in = note_slot_ff;
      note_len_in  = note_len_ff;
      note_gain_in = note_gain_ff;
      s1_valid_in  = 1'b0;
      voice_start  = 1'b0;
      voice_step   = 1'b0;
      rsp_load     = 1'b0;
      mac_ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_accept) begin
               if (req_tuser == dsvm_pkg::OP_NOTE_ON) begin
                  note_slot_in = dsvm_pkg::slot_for_note(req_note);
                  note_len_in  = sample_len_ff[note_slot_in];
                  note_gain_in = gain_rom[req_velocity];
                  if (note_len_in != '0) begin
                     state_in = ST_SCAN;
                  end
               end else if (req_tuser == dsvm_pkg::OP_FRAME) begin
                  mac_ctl.clear = 1'b1;
                  count_in      = '0;
                  state_in      = ST_ISSUE;
               end
            end
         end
         ST_SCAN: begin
            if (!voice_active_ff[cnt_ff]) begin
               voice_start = 1'b1;
               state_in    = ST_IDLE;
            end else if (cnt_last) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + VW'(1);
            end
         end
         ST_ISSUE: begin
            if (voice_active_ff[cnt_ff]) begin
               s1_valid_in = 1'b1;
               voice_step  = 1'b1;
               if (!voice_ends) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            if (cnt_last) begin
               state_in = ST_DRAIN1;
            end else begin
               cnt_in = cnt_ff + VW'(1);
            end
         end
         ST_DRAIN1: begin
            state_in = ST_DRAIN2;
         end
         ST_DRAIN2: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      mac_ctl.valid = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      count_ff     <= count_in;
      note_slot_ff <= note_slot_in;
      note_len_ff  <= note_len_in;
      note_gain_ff <= note_gain_in;
      s1_gain_ff   <= voice_gain_ff[cnt_ff];
   end

   // sample lengths; the unused slot code stays zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dsvm_pkg::SLOT_CODES; i++) begin
            sample_len_ff[i] <= '0;
         end
      end else if (mem_we && req_tlast) begin
         sample_len_ff[req_sample_id] <= dsvm_pkg::LEN_W'(req_sample_index)
                                         + dsvm_pkg::LEN_W'(1);
      end
   end

   // voice activity
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICES; i++) begin
            voice_active_ff[i] <= 1'b0;
         end
      end else if (voice_start) begin
         voice_active_ff[cnt_ff] <= 1'b1;
      end else if (voice_step && voice_ends) begin
         voice_active_ff[cnt_ff] <= 1'b0;
      end
   end

   // voice payload
   always_ff @(posedge clock) begin
      if (voice_start) begin
         voice_sample_ff[cnt_ff] <= note_slot_ff;
         voice_pos_ff[cnt_ff]    <= '0;
         voice_len_ff[cnt_ff]    <= note_len_ff;
         voice_gain_ff[cnt_ff]   <= note_gain_ff;
      end else if (voice_step) begin
         voice_pos_ff[cnt_ff] <= pos_next;
      end
   end

   // sample memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[mem_waddr] <= req_sample_value;
      end
      rd_word_ff <= sample_mem[mem_raddr];
   end

   // shared MAC
   dsvm_mac #(
      .VOICES (VOICES)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .gain  (s1_gain_ff),
      .word  (rd_word_ff),
      .mix   (mix)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {1'b0, count_ff[dsvm_pkg::COUNT_W-1:0], mix};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/dsvm_checker.sv */
// ----------------------------------------------------------------------------
// dsvm_checker
// Port-level checks for the drum sample voice mixer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dsvm_checker #(
   parameter int VOICES = 8
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic [1:0]  req_tuser,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // a frame request keeps the block busy next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == dsvm_pkg::OP_FRAME) |=> !req_tready)
      else $error("ready right after a frame request");

   // a load request leaves the block ready
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == dsvm_pkg::OP_LOAD) |=> req_tready)
      else $error("load request did not return to ready");

   // reported voice count never exceeds the pool, for pools below 15 voices
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (VOICES >= 15) || (int'(rsp_tdata[22:19]) <= VOICES))
      else $error("active voice count above pool size");

   // no response out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind drum_sample_voice_mixer_top dsvm_checker #(
   .VOICES (VOICES)
) u_dsvm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tuser  (req_tuser),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
